// ===== rtl/modbus_rtu_read_register_slave_unit_macros.svh =====
// Assertion macros shared by the RTL files of the read-register slave.
// Each macro checks on the rising edge of clk and is switched off during reset.
`ifndef MODBUS_RTU_READ_REGISTER_SLAVE_UNIT_MACROS_SVH
`define MODBUS_RTU_READ_REGISTER_SLAVE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define MBRS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MBRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define MBRS_ASSERT_SAME(label, ante, cons, msg)
`define MBRS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/mbrs_pkg.sv =====
package mbrs_pkg;

  // Request framing.
  localparam int unsigned REQUEST_LENGTH = 8;
  localparam int unsigned POS_W = 3;
  localparam logic [POS_W-1:0] LAST_REQ_POS = POS_W'(REQUEST_LENGTH - 1);

  // Protocol constants.
  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [7:0]  REPLY_BYTE_COUNT  = 8'h02;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [15:0] REQ_QUANTITY      = 16'h0001;

  // Reply byte positions.
  localparam logic [2:0] RPL_ADDR     = 3'd0;
  localparam logic [2:0] RPL_FUNC     = 3'd1;
  localparam logic [2:0] RPL_COUNT    = 3'd2;
  localparam logic [2:0] RPL_TEMP_HI  = 3'd3;
  localparam logic [2:0] RPL_TEMP_LO  = 3'd4;
  localparam logic [2:0] RPL_CRC_LO   = 3'd5;
  localparam logic [2:0] RPL_CRC_HI   = 3'd6;

  // Configuration register indexes.
  localparam logic CFG_SLAVE_ADDRESS = 1'b0;
  localparam logic CFG_HOLDING_REG   = 1'b1;

  // Temperature conversion: (sample*500 - 51150) / 1023, truncated toward zero.
  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned NUM_W     = 20;
  localparam int unsigned ABS_W     = 19;
  localparam int unsigned QUOT_W    = 10;
  localparam logic [8:0]  TEMP_GAIN = 9'd500;
  localparam logic signed [NUM_W-1:0] TEMP_OFFSET = 20'sd51150;
  localparam logic [10:0] DIVISOR   = 11'd1023;
  // 1025 / 2^20 sits just below 1/1023, so the estimate is low by at most one.
  localparam logic [10:0] RECIP     = 11'd1025;
  localparam int unsigned RECIP_SHIFT = 20;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic [15:0] holding_register_address;
  } cfg_t;

  // One accepted request waiting for its reply.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
  } job_t;

  // One byte step of the reflected CRC-16.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/mbrs_front.sv =====
module mbrs_front (
  input  logic                 clk,
  input  logic                 rst,
  input  mbrs_pkg::cfg_t       cfg,
  input  logic                 rx_valid,
  output logic                 rx_stall,
  input  logic [7:0]           rx_byte,
  input  logic [9:0]           sensor_sample,
  input  logic                 queue_full,
  output logic                 push,
  output mbrs_pkg::job_t       push_job
);
  import mbrs_pkg::*;

  `include "modbus_rtu_read_register_slave_unit_macros.svh"

  logic [POS_W-1:0] byte_position;
  logic [15:0]      running_crc;
  logic [7:0]       frame_store [0:6];

  logic        accept;
  logic        frame_end;
  logic [15:0] crc_next;
  logic        frame_ok;

  // The closing byte of a frame waits only when no queue slot is free.
  assign rx_stall  = (byte_position == LAST_REQ_POS) && queue_full;
  assign accept    = rx_valid && !rx_stall;
  assign frame_end = byte_position == LAST_REQ_POS;
  assign crc_next  = crc16_byte(running_crc, rx_byte);

  // Frame check on the closing byte: CRC residue, address, function, register, quantity.
  assign frame_ok = (crc_next == 16'h0000)
                 && (frame_store[0] == cfg.slave_address)
                 && (frame_store[1] == FUNC_READ_HOLDING)
                 && ({frame_store[2], frame_store[3]} == cfg.holding_register_address)
                 && ({frame_store[4], frame_store[5]} == REQ_QUANTITY);

  assign push            = accept && frame_end && frame_ok;
  assign push_job.sample = sensor_sample;

  // Byte counter and running CRC.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_crc   <= CRC_INIT;
    end else if (accept) begin
      if (frame_end) begin
        byte_position <= '0;
        running_crc   <= CRC_INIT;
      end else begin
        byte_position <= byte_position + 1'b1;
        running_crc   <= crc_next;
      end
    end
  end

  // Request bytes before the closing one are kept for the check.
  always_ff @(posedge clk) begin
    if (accept && !frame_end) begin
      frame_store[byte_position] <= rx_byte;
    end
  end

  `MBRS_ASSERT_SAME(a_stall_only_at_end, rx_stall, byte_position == LAST_REQ_POS, "stall before the closing byte")
  `MBRS_ASSERT_SAME(a_push_has_room, push, !queue_full, "push into a full queue")
  `MBRS_ASSERT_NEXT(a_restart_after_end, accept && frame_end, byte_position == '0 && running_crc == CRC_INIT, "framing did not restart")

endmodule

// ===== rtl/mbrs_queue.sv =====
module mbrs_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mbrs_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output mbrs_pkg::job_t pop_job,
  output logic           empty
);
  import mbrs_pkg::*;

  `include "modbus_rtu_read_register_slave_unit_macros.svh"

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  job_t             slots [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = count == FULL_CNT;
  assign empty   = count == '0;
  assign pop_job = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  `MBRS_ASSERT_SAME(a_no_pop_empty, pop, !empty, "pop from an empty queue")
  `MBRS_ASSERT_SAME(a_count_bound, 1'b1, count <= FULL_CNT, "fill count past depth")

endmodule

// ===== rtl/mbrs_back.sv =====
module mbrs_back (
  input  logic           clk,
  input  logic           rst,
  input  mbrs_pkg::cfg_t cfg,
  input  logic           queue_empty,
  input  mbrs_pkg::job_t pop_job,
  output logic           pop,
  output logic           tx_valid,
  input  logic           tx_stall,
  output logic [7:0]     tx_byte,
  output logic           last_byte
);
  import mbrs_pkg::*;

  `include "modbus_rtu_read_register_slave_unit_macros.svh"

  logic                busy;
  logic [2:0]          idx;
  logic [15:0]         reply_crc;
  logic [SAMPLE_W-1:0] sample;

  // Conversion pipeline registers.
  logic [ABS_W-1:0]  num_abs;
  logic              num_neg;
  logic [ABS_W-1:0]  est_abs;
  logic              est_neg;
  logic [QUOT_W-1:0] est_quot;
  logic [15:0]       temp;

  logic                           load;
  logic [7:0]                     cur_byte;
  logic signed [NUM_W-1:0]        num;
  logic [ABS_W+10:0]              est_prod;
  logic [ABS_W-1:0]               rem;
  logic [QUOT_W-1:0]              quot;

  assign load = busy && (!tx_valid || !tx_stall);
  assign pop  = !queue_empty && (!busy || (load && idx == RPL_CRC_HI));

  // Stage one: signed numerator and its magnitude.
  assign num = $signed({1'b0, (NUM_W-1)'(sample * TEMP_GAIN)}) - TEMP_OFFSET;

  // Stage two: quotient estimate by reciprocal multiply.
  assign est_prod = num_abs * RECIP;

  // Stage three: one correction step, then the sign.
  assign rem  = est_abs - ABS_W'({est_quot, 10'd0} - {10'd0, est_quot});
  assign quot = (rem >= ABS_W'(DIVISOR)) ? est_quot + 1'b1 : est_quot;

  // The conversion runs while the three header bytes go out.
  always_ff @(posedge clk) begin
    num_abs  <= num[NUM_W-1] ? ABS_W'(-num) : ABS_W'(num);
    num_neg  <= num[NUM_W-1];
    est_abs  <= num_abs;
    est_neg  <= num_neg;
    est_quot <= est_prod[RECIP_SHIFT +: QUOT_W];
    temp     <= est_neg ? 16'(-{6'd0, quot}) : {6'd0, quot};
  end

  // Reply byte selection.
  always_comb begin
    case (idx)
      RPL_ADDR:    cur_byte = cfg.slave_address;
      RPL_FUNC:    cur_byte = FUNC_READ_HOLDING;
      RPL_COUNT:   cur_byte = REPLY_BYTE_COUNT;
      RPL_TEMP_HI: cur_byte = temp[15:8];
      RPL_TEMP_LO: cur_byte = temp[7:0];
      RPL_CRC_LO:  cur_byte = reply_crc[7:0];
      RPL_CRC_HI:  cur_byte = reply_crc[15:8];
      default:     cur_byte = 8'h00;
    endcase
  end

  // Sequencer and output register control; a new job takes over from the last byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      tx_valid  <= 1'b0;
      reply_crc <= CRC_INIT;
    end else begin
      if (load) begin
        tx_valid <= 1'b1;
      end else if (!tx_stall) begin
        tx_valid <= 1'b0;
      end
      if (pop) begin
        busy      <= 1'b1;
        idx       <= '0;
        reply_crc <= CRC_INIT;
      end else if (load) begin
        idx <= idx + 1'b1;
        if (idx == RPL_CRC_HI) begin
          busy <= 1'b0;
        end
        if (idx < RPL_CRC_LO) begin
          reply_crc <= crc16_byte(reply_crc, cur_byte);
        end
      end
    end
  end

  // Job and output payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      sample <= pop_job.sample;
    end
    if (load) begin
      tx_byte   <= cur_byte;
      last_byte <= idx == RPL_CRC_HI;
    end
  end

  `MBRS_ASSERT_SAME(a_idx_range, busy, idx <= RPL_CRC_HI, "reply index past the last byte")
  `MBRS_ASSERT_SAME(a_pop_when_done, pop && busy, load && idx == RPL_CRC_HI, "early pop")
  `MBRS_ASSERT_NEXT(a_last_ends_reply, load && idx == RPL_CRC_HI && !pop, !busy, "busy after reply")

endmodule

// ===== rtl/modbus_rtu_read_register_slave_unit.sv =====
// Modbus RTU read-holding-register slave for one temperature register. Request
// bytes are taken one per cycle unless stalled and counted into fixed 8-byte
// frames (no inter-frame timeout, so a lost byte shifts all later frames). A
// frame with a good CRC-16, the configured address, function 0x03, the
// configured register and a quantity of one queues a reply built from the sensor
// sample that came with its eighth byte; any other frame is dropped silently.
// The reply is seven bytes, one per cycle while tx_stall is low, last_byte
// marking the final CRC byte. A free sequencer pops queued replies in order.
// Reception stalls only on the eighth byte of a frame, and only while all
// QUEUE_DEPTH pending-reply slots are taken; a reply occupies the sequencer
// for its seven bytes, against eight input bytes per frame, so a steady stream
// runs at one byte per cycle while tx_stall is low. Write registers through
// cfg_write_enable only while no reply is pending; the block does not check.
module modbus_rtu_read_register_slave_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic        cfg_index,
  input  logic [15:0] cfg_write_data,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  input  logic [9:0]  sensor_sample,
  output logic        tx_valid,
  input  logic        tx_stall,
  output logic [7:0]  tx_byte,
  output logic        last_byte
);
  import mbrs_pkg::*;

  cfg_t cfg;
  logic push;
  job_t push_job;
  logic queue_full;
  logic pop;
  job_t pop_job;
  logic queue_empty;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slave_address            <= 8'd2;
      cfg.holding_register_address <= 16'd1;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        CFG_SLAVE_ADDRESS: cfg.slave_address            <= cfg_write_data[7:0];
        CFG_HOLDING_REG:   cfg.holding_register_address <= cfg_write_data;
        default:           cfg                          <= cfg;
      endcase
    end
  end

  mbrs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .rx_valid      (rx_valid),
    .rx_stall      (rx_stall),
    .rx_byte       (rx_byte),
    .sensor_sample (sensor_sample),
    .queue_full    (queue_full),
    .push          (push),
    .push_job      (push_job)
  );

  mbrs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (queue_empty)
  );

  mbrs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .queue_empty (queue_empty),
    .pop_job     (pop_job),
    .pop         (pop),
    .tx_valid    (tx_valid),
    .tx_stall    (tx_stall),
    .tx_byte     (tx_byte),
    .last_byte   (last_byte)
  );

endmodule

// ===== test/modbus_rtu_read_register_slave_unit_test.sv =====
`timescale 1ns / 100ps

module modbus_rtu_read_register_slave_unit_test;
  import mbrs_pkg::*;

  // One byte of a reply frame as it should leave the block.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } reply_byte_t;

  // Ways in which a random request frame is spoiled so that it gets no reply.
  typedef enum int {
    FLAW_CRC,
    FLAW_ADDRESS,
    FLAW_FUNCTION,
    FLAW_REGISTER,
    FLAW_QUANTITY
  } frame_flaw_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_enable = 1'b0;
  logic        cfg_index = CFG_SLAVE_ADDRESS;
  logic [15:0] cfg_write_data = 16'h0000;
  logic        rx_valid = 1'b0;
  logic        rx_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic [9:0]  sensor_sample = 10'd0;
  logic        tx_valid;
  logic        tx_stall = 1'b0;
  logic [7:0]  tx_byte;
  logic        last_byte;

  // Settings and framing state as the block should hold them.
  logic [7:0]  answer_address = 8'd2;
  logic [15:0] answer_register = 16'd1;
  logic [2:0]  frame_position = 3'd0;
  logic [7:0]  frame_bytes [0:6];
  logic [15:0] frame_crc = CRC_INIT;

  reply_byte_t expected_reply_bytes [$];
  int          mismatch_count = 0;
  bit          steady_flow = 1'b0;
  int          long_hold_request = 0;
  int          stall_left = 0;

  modbus_rtu_read_register_slave_unit uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_write_data   (cfg_write_data),
    .rx_valid         (rx_valid),
    .rx_stall         (rx_stall),
    .rx_byte          (rx_byte),
    .sensor_sample    (sensor_sample),
    .tx_valid         (tx_valid),
    .tx_stall         (tx_stall),
    .tx_byte          (tx_byte),
    .last_byte        (last_byte)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Give up well after the slowest legal run would have finished.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Reflected CRC-16 over one byte, least significant bit first.
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    int          k;
    c = crc ^ {8'h00, data};
    for (k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Temperature in degrees: (sample*500 - 51150) / 1023, truncated toward zero.
  function automatic logic [15:0] temperature_code(input logic [9:0] sample);
    int t;
    t = int'(sample) * 500 - 51150;
    t = t / 1023;
    return t[15:0];
  endfunction

  // Advance the framing state by one request byte and queue any reply it causes.
  function automatic void predict_request_byte(input logic [7:0] data, input logic [9:0] sample);
    logic [7:0]  reply [0:6];
    logic [15:0] temperature;
    logic [15:0] reply_crc;
    bit          accepted;
    int          k;
    frame_crc = crc16_step(frame_crc, data);
    if (frame_position != LAST_REQ_POS) begin
      frame_bytes[frame_position] = data;
      frame_position = frame_position + 3'd1;
    end else begin
      accepted = frame_crc == 16'h0000
        && frame_bytes[0] == answer_address
        && frame_bytes[1] == FUNC_READ_HOLDING
        && {frame_bytes[2], frame_bytes[3]} == answer_register
        && {frame_bytes[4], frame_bytes[5]} == REQ_QUANTITY;
      frame_position = 3'd0;
      frame_crc = CRC_INIT;
      if (accepted) begin
        temperature = temperature_code(sample);
        reply[0] = answer_address;
        reply[1] = FUNC_READ_HOLDING;
        reply[2] = REPLY_BYTE_COUNT;
        reply[3] = temperature[15:8];
        reply[4] = temperature[7:0];
        reply_crc = CRC_INIT;
        for (k = 0; k < 5; k++) begin
          reply_crc = crc16_step(reply_crc, reply[k]);
        end
        reply[5] = reply_crc[7:0];
        reply[6] = reply_crc[15:8];
        for (k = 0; k < 7; k++) begin
          expected_reply_bytes.push_back({reply[k], k == 6});
        end
      end
    end
  endfunction

  // A read request with its CRC appended, byte 0 in the low bits.
  function automatic logic [63:0] build_request(input logic [7:0] addr, input logic [7:0] func,
                                                input logic [15:0] reg_addr,
                                                input logic [15:0] quantity);
    logic [63:0] f;
    logic [15:0] crc;
    int          k;
    f = {16'h0000, quantity[7:0], quantity[15:8], reg_addr[7:0], reg_addr[15:8], func, addr};
    crc = CRC_INIT;
    for (k = 0; k < 6; k++) begin
      crc = crc16_step(crc, f[8*k +: 8]);
    end
    f[55:48] = crc[7:0];
    f[63:56] = crc[15:8];
    return f;
  endfunction

  // Mostly short idle stretches, now and then a long one.
  function automatic int pick_idle_cycles();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
  endfunction

  function automatic logic [9:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 10'd0;
      1: return 10'd1023;
      2: return 10'($urandom_range(95, 110));
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  // Offer one request byte and hold it until the block takes it.
  task automatic send_request_byte(input logic [7:0] data, input logic [9:0] sample);
    int idle;
    idle = (steady_flow || $urandom_range(0, 1) == 0) ? 0 : pick_idle_cycles();
    if (idle != 0) begin
      rx_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= data;
    sensor_sample <= sample;
    do @(posedge clk); while (rx_stall);
    predict_request_byte(data, sample);
  endtask

  // Send eight bytes; only the sample that comes with the last one matters.
  task automatic send_request_frame(input logic [63:0] f, input logic [9:0] sample);
    int k;
    for (k = 0; k < 8; k++) begin
      send_request_byte(f[8*k +: 8], (k == 7) ? sample : 10'($urandom_range(0, 1023)));
    end
  endtask

  // Let every pending reply drain, plus a margin for a frame still being checked.
  task automatic wait_for_replies();
    rx_valid <= 1'b0;
    while (expected_reply_bytes.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_register(input logic index, input logic [15:0] data);
    cfg_write_enable <= 1'b1;
    cfg_index <= index;
    cfg_write_data <= data;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    @(posedge clk);
    if (index == CFG_SLAVE_ADDRESS) begin
      answer_address = data[7:0];
    end else begin
      answer_register = data;
    end
  endtask

  // Mostly good requests with random samples; the rest are spoiled or misaligned.
  task automatic send_random_frame();
    logic [63:0] f;
    logic [7:0]  func;
    logic [15:0] quantity;
    frame_flaw_t flaw;
    int          pick;
    int          k;
    pick = $urandom_range(0, 19);
    f = build_request(answer_address, FUNC_READ_HOLDING, answer_register, REQ_QUANTITY);
    if (pick < 13) begin
      send_request_frame(f, pick_sample());
    end else if (pick < 18) begin
      flaw = frame_flaw_t'($urandom_range(0, 4));
      case (flaw)
        FLAW_CRC: begin
          k = 48 + $urandom_range(0, 15);
          f[k] = ~f[k];
        end
        FLAW_ADDRESS: begin
          f = build_request(answer_address ^ 8'($urandom_range(1, 255)), FUNC_READ_HOLDING,
                            answer_register, REQ_QUANTITY);
        end
        FLAW_FUNCTION: begin
          func = 8'($urandom_range(0, 255));
          if (func == FUNC_READ_HOLDING) func = func ^ 8'h80;
          f = build_request(answer_address, func, answer_register, REQ_QUANTITY);
        end
        FLAW_REGISTER: begin
          f = build_request(answer_address, FUNC_READ_HOLDING,
                            answer_register ^ 16'($urandom_range(1, 65535)), REQ_QUANTITY);
        end
        default: begin
          quantity = 16'($urandom);
          if (quantity == REQ_QUANTITY) quantity = 16'h0002;
          f = build_request(answer_address, FUNC_READ_HOLDING, answer_register, quantity);
        end
      endcase
      send_request_frame(f, pick_sample());
    end else begin
      // An extra byte shifts a good frame out of place; seven more restore framing.
      send_request_byte(8'($urandom), 10'($urandom_range(0, 1023)));
      send_request_frame(f, pick_sample());
      for (k = 0; k < 7; k++) begin
        send_request_byte(8'($urandom), 10'($urandom_range(0, 1023)));
      end
    end
  endtask

  // Register values from reset, both temperature extremes and a CRC error.
  task automatic test_reset_settings();
    logic [63:0] f;
    f = build_request(8'd2, FUNC_READ_HOLDING, 16'd1, REQ_QUANTITY);
    send_request_frame(f, 10'd0);
    send_request_frame(f, 10'd1023);
    f[63] = ~f[63];
    send_request_frame(f, 10'd500);
  endtask

  task automatic test_random_traffic(input int frames);
    repeat (frames) send_random_frame();
  endtask

  // Both registers at their extremes, then at random values.
  task automatic test_register_extremes();
    wait_for_replies();
    write_register(CFG_SLAVE_ADDRESS, 16'hA500);
    write_register(CFG_HOLDING_REG, 16'h0000);
    test_random_traffic(4);
    wait_for_replies();
    write_register(CFG_SLAVE_ADDRESS, 16'h00FF);
    write_register(CFG_HOLDING_REG, 16'hFFFF);
    test_random_traffic(4);
    wait_for_replies();
    write_register(CFG_SLAVE_ADDRESS, 16'($urandom));
    write_register(CFG_HOLDING_REG, 16'($urandom));
    test_random_traffic(4);
  endtask

  // Hold the reply side for a long stretch while good requests keep coming.
  task automatic test_back_pressure();
    logic [63:0] f;
    int          k;
    f = build_request(answer_address, FUNC_READ_HOLDING, answer_register, REQ_QUANTITY);
    steady_flow = 1'b1;
    long_hold_request = 300;
    for (k = 0; k < 5; k++) begin
      send_request_frame(f, pick_sample());
    end
    steady_flow = 1'b0;
  endtask

  // Reply side stall: random gaps, or one long hold when a test asks for it.
  always @(posedge clk) begin
    if (long_hold_request != 0) begin
      stall_left = long_hold_request;
      long_hold_request = 0;
    end else if (stall_left == 0 && !steady_flow && $urandom_range(0, 3) == 0) begin
      stall_left = pick_idle_cycles();
    end
    if (stall_left != 0) begin
      tx_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      tx_stall <= 1'b0;
    end
  end

  // Compare every reply byte that leaves the block with the oldest one expected.
  always @(posedge clk) begin
    reply_byte_t want;
    if (!rst && tx_valid === 1'b1 && tx_stall == 1'b0) begin
      if (expected_reply_bytes.size() == 0) begin
        $display("%0t: unexpected reply byte, expected none, got tx_byte %02h last_byte %0b",
                 $time, tx_byte, last_byte);
        mismatch_count++;
      end else begin
        want = expected_reply_bytes.pop_front();
        if (tx_byte !== want.data) begin
          $display("%0t: tx_byte expected %02h, got %02h", $time, want.data, tx_byte);
          mismatch_count++;
        end
        if (last_byte !== want.last) begin
          $display("%0t: last_byte expected %0b, got %0b", $time, want.last, last_byte);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_settings();
    test_random_traffic(6);
    test_register_extremes();
    test_back_pressure();
    test_random_traffic(4);
    wait_for_replies();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
